// File: src/lru_record_cache_tags_unit_assert.svh
// Assertion macros used by the cache tag unit datapath.
`ifndef LRU_RECORD_CACHE_TAGS_UNIT_ASSERT_SVH
`define LRU_RECORD_CACHE_TAGS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LRCT_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);
`define LRCT_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`else
`define LRCT_ASSERT_IMPLY(label, clk, rst, cond, expr, msg)
`define LRCT_ASSERT_NEXT(label, clk, rst, cond, expr, msg)
`endif
`endif

// File: src/lrct_pkg.sv
// Shared constants, types and helpers of the cache tag unit.
`timescale 1ns / 1ps
`default_nettype none
package lrct_pkg;
   localparam int MAX_ENTRIES = 16;
   localparam int KEY_BITS    = 20;
   localparam int SLOT_BITS   = $clog2(MAX_ENTRIES);
   localparam int RANK_BITS   = SLOT_BITS;
   localparam int COUNT_BITS  = $clog2(MAX_ENTRIES + 1);
   localparam int CAP_BITS    = 5;
   localparam int CAP_RESET   = 10;
   localparam int ADDR_BITS   = 3;
   localparam int DATA_BITS   = 32;

   // word index of the register (paddr above the byte offset)
   localparam logic [ADDR_BITS-3:0] REG_ENTRIES_IN_USE = '0;

   typedef struct packed {
      logic load_key;
      logic lookup;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   // lowest set bit of a slot vector
   function automatic logic [SLOT_BITS-1:0] first_set(input logic [MAX_ENTRIES-1:0] vec);
      logic [SLOT_BITS-1:0] idx;
      idx = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = SLOT_BITS'(i);
         end
      end
      return idx;
   endfunction
endpackage
`default_nettype wire

// File: src/lrct_ctrl.sv
// Sequencer of the cache tag unit: accept, lookup, commit.
`timescale 1ns / 1ps
`default_nettype none
module lrct_ctrl import lrct_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  dp_status_type      status,
   output dp_cmd_type         cmd
);
   typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_COMMIT} state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: state_in = ST_COMMIT;
         ST_COMMIT: begin
            // hold until the result register has room
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign cmd.load_key = req_valid && (state_ff == ST_IDLE);
   assign cmd.lookup   = (state_ff == ST_LOOKUP);
   assign cmd.commit   = (state_ff == ST_COMMIT) && status.out_free;
endmodule
`default_nettype wire

// File: src/lrct_datapath.sv
// Tag store, recency ranks, lookup registers and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_record_cache_tags_unit_assert.svh"
module lrct_datapath import lrct_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  dp_cmd_type                cmd,
   output dp_status_type             status,
   input  wire logic [CAP_BITS-1:0]  cap,
   input  wire logic [KEY_BITS-1:0]  req_record_key,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_hit,
   output logic [SLOT_BITS-1:0]      rsp_slot,
   output logic                      rsp_evicted,
   output logic [KEY_BITS-1:0]       rsp_evicted_key
);
   logic [KEY_BITS-1:0]   key_ff;
   logic [KEY_BITS-1:0]   tag_ff [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [RANK_BITS-1:0]  rank_ff [MAX_ENTRIES];
   logic [RANK_BITS-1:0]  rank_in [MAX_ENTRIES];
   logic [COUNT_BITS-1:0] held_ff, held_in;

   logic                  hit_ff, has_room_ff;
   logic [SLOT_BITS-1:0]  hit_slot_ff, free_slot_ff, lru_slot_ff;
   logic [RANK_BITS-1:0]  hit_rank_ff;

   logic                  rsp_valid_ff, rsp_hit_ff, rsp_evicted_ff;
   logic [SLOT_BITS-1:0]  rsp_slot_ff;
   logic [KEY_BITS-1:0]   rsp_evicted_key_ff;

   logic [MAX_ENTRIES-1:0] match_vec, lru_vec;
   logic [COUNT_BITS-1:0]  eff_cap;
   logic [RANK_BITS-1:0]   oldest_rank;
   logic [SLOT_BITS-1:0]   hit_slot, slot_sel;
   logic                   evict;

   // clamp capacity to 1..MAX_ENTRIES
   always_comb begin
      if (cap == '0) begin
         eff_cap = COUNT_BITS'(1);
      end else if (32'(cap) > MAX_ENTRIES) begin
         eff_cap = COUNT_BITS'(MAX_ENTRIES);
      end else begin
         eff_cap = COUNT_BITS'(cap);
      end
   end

   // the least recent valid entry carries rank held_count-1
   assign oldest_rank = RANK_BITS'(held_ff - COUNT_BITS'(1));

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match_vec[i] = valid_ff[i] && (tag_ff[i] == key_ff);
         lru_vec[i]   = valid_ff[i] && (rank_ff[i] == oldest_rank);
      end
   end

   assign hit_slot = first_set(match_vec);

   always_ff @(posedge clock) begin
      if (cmd.load_key) key_ff <= req_record_key;
      if (cmd.lookup) begin
         hit_ff       <= |match_vec;
         hit_slot_ff  <= hit_slot;
         hit_rank_ff  <= rank_ff[hit_slot];
         free_slot_ff <= first_set(~valid_ff);
         lru_slot_ff  <= first_set(lru_vec);
         has_room_ff  <= held_ff < eff_cap;
      end
   end

   // commit: pick the slot, age the others, update tags
   assign evict    = !hit_ff && !has_room_ff;
   assign slot_sel = hit_ff ? hit_slot_ff : (has_room_ff ? free_slot_ff : lru_slot_ff);

   always_comb begin
      valid_in = valid_ff;
      held_in  = held_ff;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (cmd.commit) begin
         valid_in[slot_sel] = 1'b1;
         if (!hit_ff && has_room_ff) held_in = held_ff + COUNT_BITS'(1);
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (SLOT_BITS'(i) == slot_sel) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (!hit_ff || rank_ff[i] < hit_rank_ff)) begin
               rank_in[i] = rank_ff[i] + RANK_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         held_ff  <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         held_ff  <= held_in;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && !hit_ff) tag_ff[slot_sel] <= key_ff;
      if (cmd.commit) begin
         rsp_hit_ff         <= hit_ff;
         rsp_slot_ff        <= slot_sel;
         rsp_evicted_ff     <= evict;
         rsp_evicted_key_ff <= evict ? tag_ff[lru_slot_ff] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_key  = rsp_evicted_key_ff;

   `LRCT_ASSERT_IMPLY(a_count_matches_valid, clock, reset, 1'b1, $countones(valid_ff) == int'(held_ff), "held count differs from valid entries")
   `LRCT_ASSERT_IMPLY(a_single_match, clock, reset, cmd.lookup, $onehot0(match_vec), "key held in more than one slot")
   `LRCT_ASSERT_IMPLY(a_victim_valid, clock, reset, cmd.commit && evict, valid_ff[lru_slot_ff], "eviction victim is not a valid entry")
   `LRCT_ASSERT_NEXT(a_evict_keeps_count, clock, reset, cmd.commit && evict, held_ff == $past(held_ff), "eviction changed held count")
endmodule
`default_nettype wire

// File: src/lru_record_cache_tags_unit.sv
// Top level of the fully associative LRU cache tag unit.
// Usage:
//  - Request channel (req_valid/req_ready, req_record_key): one item per lookup.
//  - Result channel (rsp_valid/rsp_ready): one item per request carrying
//    rsp_hit, rsp_slot, rsp_evicted and rsp_evicted_key (zero when no eviction).
//  - APB-style register port: entries_in_use at byte address 0 (5 bits, reset 10);
//    0 acts as 1, values above the slot count act as the slot count.
//    Write it only while no request is in flight.
// Flow: an accepted item passes the lookup registers and then the result register,
//  where it shows on rsp_valid. Each item runs accept, lookup (parallel tag compare,
//  registered) and commit (rank update and tag write); the next item is taken in the
//  cycle after commit, since the three-step sequencer takes no new item before then.
// Stall: the result register holds its item until rsp_ready; a new item is
//  accepted and looked up meanwhile, and its commit waits for the register.
// Reset: all entries invalid, ranks and held count zero, capacity back to 10;
//  the tag store is not cleared, it is read only for valid entries.
`timescale 1ns / 1ps
`default_nettype none
module lru_record_cache_tags_unit import lrct_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [KEY_BITS-1:0]   req_record_key,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_hit,
   output logic [SLOT_BITS-1:0]       rsp_slot,
   output logic                       rsp_evicted,
   output logic [KEY_BITS-1:0]        rsp_evicted_key,
   // register port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [ADDR_BITS-1:0]  paddr,
   input  wire logic [DATA_BITS-1:0]  pwdata,
   output logic [DATA_BITS-1:0]       prdata,
   output logic                       pready
);
   logic [CAP_BITS-1:0] cap_ff;
   logic                cap_sel;
   dp_cmd_type          cmd;
   dp_status_type       status;

   // single register: decode the word index, ignore the byte offset
   assign cap_sel = (paddr[ADDR_BITS-1:2] == REG_ENTRIES_IN_USE);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_BITS'(CAP_RESET);
      end else if (psel && penable && pwrite && cap_sel) begin
         cap_ff <= pwdata[CAP_BITS-1:0];
      end
   end

   // read back: capacity register, zero elsewhere
   assign prdata = cap_sel ? DATA_BITS'(cap_ff) : '0;

   lrct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lrct_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .cap             (cap_ff),
      .req_record_key  (req_record_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key)
   );
endmodule
`default_nettype wire

// File: bench/lru_record_cache_tags_unit_tb.sv
// Self-checking testbench for the LRU record cache tag unit.
`timescale 1ns / 1ps
module lru_record_cache_tags_unit_tb;
   import lrct_pkg::*;

   // Word index past the only register; writes there must not land anywhere.
   localparam int REG_SPARE    = 1;
   // Cycles without any handshake before the run is declared hung.
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 172;
   localparam int HOT_MAX      = 24;

   // One lookup outcome, together with the key that caused it.
   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic                hit;
      logic [SLOT_BITS-1:0] slot;
      logic                evicted;
      logic [KEY_BITS-1:0] evicted_key;
   } lookup_type;

   // Shadow of the tag unit: tags, valid bits, recency ages and capacity.
   // Predicts each lookup on request accept and compares on result accept.
   class lookup_scoreboard;
      logic [KEY_BITS-1:0] tags [MAX_ENTRIES];
      bit                  held_mask [MAX_ENTRIES];
      int                  age [MAX_ENTRIES];
      int                  held;
      logic [CAP_BITS-1:0] capacity;
      lookup_type          pending_lookups [$];
      int                  mismatches;
      int                  lookups, hits, fills, evictions, cap_writes;

      function new();
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            tags[i]      = '0;
            held_mask[i] = 1'b0;
            age[i]       = 0;
         end
         held       = 0;
         capacity   = CAP_BITS'(CAP_RESET);
         mismatches = 0;
         lookups    = 0;
         hits       = 0;
         fills      = 0;
         evictions  = 0;
         cap_writes = 0;
      endfunction

      function void write_register(int idx, logic [DATA_BITS-1:0] value);
         if (idx == int'(REG_ENTRIES_IN_USE)) begin
            capacity = value[CAP_BITS-1:0];
            cap_writes++;
         end
      endfunction

      function int pending();
         return pending_lookups.size();
      endfunction

      task report_mismatch(string what, logic [KEY_BITS-1:0] key,
                           logic [31:0] got, logic [31:0] want);
         mismatches++;
         $display("[%0t] MISMATCH %s (key %05h): got %0h, want %0h",
                  $realtime, what, key, got, want);
      endtask

      // Look the key up, update the shadow state and queue the outcome.
      function void predict_lookup(logic [KEY_BITS-1:0] key);
         lookup_type r;
         int s, cap, limit, best;
         r     = '0;
         r.key = key;
         s     = -1;
         for (int i = 0; i < MAX_ENTRIES; i++)
            if (s < 0 && held_mask[i] && tags[i] == key) s = i;
         cap = int'(capacity);
         if (cap == 0) cap = 1;
         if (cap > MAX_ENTRIES) cap = MAX_ENTRIES;
         if (s >= 0) begin
            r.hit = 1'b1;
            limit = age[s];
            hits++;
         end else begin
            limit = MAX_ENTRIES;
            if (held < cap) begin
               // lowest free slot
               for (int i = 0; i < MAX_ENTRIES; i++)
                  if (s < 0 && !held_mask[i]) s = i;
               held++;
               fills++;
            end else begin
               // oldest held entry goes; ties cannot happen among held slots
               best = -1;
               for (int i = 0; i < MAX_ENTRIES; i++)
                  if (held_mask[i] && age[i] > best) begin
                     s    = i;
                     best = age[i];
                  end
               r.evicted     = 1'b1;
               r.evicted_key = tags[s];
               evictions++;
            end
            held_mask[s] = 1'b1;
            tags[s]      = key;
         end
         for (int i = 0; i < MAX_ENTRIES; i++)
            if (held_mask[i] && i != s && age[i] < limit) age[i]++;
         age[s] = 0;
         r.slot = SLOT_BITS'(s);
         lookups++;
         pending_lookups = {pending_lookups, r};
      endfunction

      task check_lookup(logic hit, logic [SLOT_BITS-1:0] slot,
                        logic evicted, logic [KEY_BITS-1:0] evicted_key);
         lookup_type w;
         if (pending_lookups.size() == 0) begin
            report_mismatch("unexpected result", '0, 32'(slot), '0);
            return;
         end
         w = pending_lookups[0];
         pending_lookups.delete(0);
         if (hit !== w.hit) report_mismatch("hit", w.key, 32'(hit), 32'(w.hit));
         if (slot !== w.slot) report_mismatch("slot", w.key, 32'(slot), 32'(w.slot));
         if (evicted !== w.evicted)
            report_mismatch("evicted", w.key, 32'(evicted), 32'(w.evicted));
         if (evicted_key !== w.evicted_key)
            report_mismatch("evicted_key", w.key, 32'(evicted_key), 32'(w.evicted_key));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [KEY_BITS-1:0]  req_record_key = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_hit;
   logic [SLOT_BITS-1:0] rsp_slot;
   logic                 rsp_evicted;
   logic [KEY_BITS-1:0]  rsp_evicted_key;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ADDR_BITS-1:0] paddr = '0;
   logic [DATA_BITS-1:0] pwdata = '0;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   lookup_scoreboard sb = new();

   // When set, the bench adds no idle cycles of its own on either channel.
   bit no_idle = 1'b0;

   logic [KEY_BITS-1:0] hot_keys [HOT_MAX];
   int                  hot_count;

   lru_record_cache_tags_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_record_key  (req_record_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // 12 ns period: high half, then low half.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Pick the idle cycles ahead of the next item on either side.
   function automatic int draw_wait();
      if (no_idle) return 0;
      return $urandom_range(0, 18);
   endfunction

   // Present one key and hold it until the block takes it. Called right
   // after an accept edge (or from idle), so the first negedge is the
   // earliest point to change the payload; valid stays high on a zero gap.
   task automatic send_request(input logic [KEY_BITS-1:0] key);
      int gap;
      gap = draw_wait();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_record_key = key;
      do @(posedge clock); while (!req_ready);
      sb.predict_lookup(key);
   endtask

   // Drop valid, then hold until every predicted result has been taken,
   // and let the unit settle before any write.
   task automatic quiesce();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the write lands on the edge with pready.
   task automatic csr_write(input int reg_idx, input logic [DATA_BITS-1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = ADDR_BITS'(reg_idx << 2);
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_register(reg_idx, value);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // Result side: stall a random number of cycles per item, then take it.
   initial begin
      int stall;
      wait (!reset);
      forever begin
         stall = draw_wait();
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_lookup(rsp_hit, rsp_slot, rsp_evicted, rsp_evicted_key);
      end
   end

   // Hang detector: count edges on which neither channel moves an item.
   initial begin
      int quiet;
      quiet = 0;
      wait (!reset);
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[%0t] no handshake for %0d cycles, %0d results outstanding",
               $realtime, STALL_LIMIT, sb.pending());
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      logic [CAP_BITS-1:0] phase_cap [PHASES];
      logic [KEY_BITS-1:0] key;

      // Extremes first: 16 exactly, 1, out-of-range high, zero (acts as 1).
      phase_cap = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd17, 5'd10, 5'd7, 5'd15, 5'd3};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset capacity of 10, extreme keys, a hit, fill to capacity,
      // then two evictions and a hit on a surviving entry.
      send_request(20'h00000);
      send_request(20'hFFFFF);
      send_request(20'h00000);
      send_request(20'h80000);
      send_request(20'h00001);
      send_request(20'h12345);
      send_request(20'hEDCBA);
      send_request(20'h55555);
      send_request(20'hAAAAA);
      send_request(20'h7FFFF);
      send_request(20'h00010);
      send_request(20'h3C3C3);
      send_request(20'hFFFFF);
      send_request(20'h12345);

      // Capacity of zero behaves as one; held entries stay above it, so
      // every miss evicts the oldest one.
      quiesce();
      csr_write(int'(REG_ENTRIES_IN_USE), 0);
      send_request(20'h0F0F0);
      send_request(20'h0F0F0);
      send_request(20'h00000);

      // A write to the unmapped word must leave the capacity alone.
      quiesce();
      csr_write(REG_SPARE, 32'h0000_0003);
      send_request(20'h11111);

      // Out-of-range capacity clamps to the slot count: free slots refill.
      quiesce();
      csr_write(int'(REG_ENTRIES_IN_USE), 31);
      send_request(20'h22222);
      send_request(20'h33333);
      send_request(20'h44444);
      send_request(20'h22222);

      // Random phases: mostly keys from a small working set so hits and
      // evictions both happen; the rest are fresh random keys.
      for (int p = 0; p < PHASES; p++) begin
         quiesce();
         if (p == PHASES - 1) phase_cap[p] = CAP_BITS'($urandom_range(1, 31));
         csr_write(int'(REG_ENTRIES_IN_USE), 32'(phase_cap[p]));
         no_idle   = (p == 2 || p == 7);
         hot_count = $urandom_range(2, HOT_MAX);
         for (int h = 0; h < HOT_MAX; h++) hot_keys[h] = KEY_BITS'($urandom);
         if (p % 3 == 0) begin
            hot_keys[0] = '0;
            hot_keys[1] = '1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Hold the sender until the result side has caught up.
            if (p == 4 && n == PHASE_ITEMS / 2) begin
               @(negedge clock);
               req_valid = 1'b0;
               while (sb.pending() > 0) @(posedge clock);
            end
            if ($urandom_range(0, 99) < 85)
               key = hot_keys[$urandom_range(0, hot_count - 1)];
            else
               key = KEY_BITS'($urandom);
            send_request(key);
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Ran %0d lookups: %0d hits, %0d free-slot fills, %0d evictions",
               sb.lookups, sb.hits, sb.fills, sb.evictions);
      $display("Capacity written %0d times (0, 1, 16 and 31 among them); %0d mismatches",
               sb.cap_writes, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

// File: files.f
+incdir+src
src/lrct_pkg.sv
src/lrct_ctrl.sv
src/lrct_datapath.sv
src/lru_record_cache_tags_unit.sv
bench/lru_record_cache_tags_unit_tb.sv
